[hw/rtl/bcpe_pkg.sv]
// Shared constants and types for the Bezier curve point evaluator.
package bcpe_pkg;

    localparam int PARAM_W    = 17;
    localparam int COORD_W    = 16;
    localparam int CTRL_W     = 48;
    localparam int NUM_CTRL   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int AXES       = 3;
    localparam int MAX_DEGREE = 7;
    localparam int BINOM_W    = 6;

    localparam logic [BINOM_W-1:0] BINOM [MAX_DEGREE+1][MAX_DEGREE+1] = '{
        '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
        '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
        '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
    };

    typedef struct packed {
        logic mul;
        logic sum;
        logic rnd;
    } adv_t;

endpackage

[hw/rtl/bezier_curve_point_eval.sv]
// Top level of the cubic Bezier curve point evaluator in Bernstein form.
//
//   channel | handshake              | beat contents
//   --------+------------------------+-------------------------------------
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (packed z y x)
//   param   | param_valid / stall    | curve_param (t, Q1.PARAM_FRAC_BITS)
//   point   | point_valid / stall    | point_x, point_y, point_z (Q8.8)
//
// One beat is accepted per cycle unless param_stall is high.
// The depth is set by one power multiply stage per degree plus six fixed stages.
// Reset clears the control points and all valid bits; cfg_ready is always high.
// A stall holds only the stages that are full, so bubbles are squeezed out.
module bezier_curve_point_eval #(
    parameter int DEGREE          = 3,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bcpe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bcpe_pkg::CTRL_W-1:0]           cfg_data,
    input  logic                                  param_valid,
    output logic                                  param_stall,
    input  logic [bcpe_pkg::PARAM_W-1:0]          curve_param,
    output logic                                  point_valid,
    input  logic                                  point_stall,
    output logic signed [bcpe_pkg::COORD_W-1:0]   point_x,
    output logic signed [bcpe_pkg::COORD_W-1:0]   point_y,
    output logic signed [bcpe_pkg::COORD_W-1:0]   point_z
);

    localparam int TW    = PARAM_FRAC_BITS + 1;
    localparam int CW    = (TW > bcpe_pkg::PARAM_W) ? TW : bcpe_pkg::PARAM_W;
    localparam int PRW   = 2 * TW;
    localparam int CPW   = PRW + bcpe_pkg::BINOM_W;
    localparam int WW    = PARAM_FRAC_BITS + 6;
    localparam int NSTG  = DEGREE + 6;
    localparam int PS    = DEGREE + 1;
    localparam int WS    = DEGREE + 2;
    localparam int LAST  = NSTG - 1;

    localparam logic [TW-1:0]  ONE_T  = TW'(1) << PARAM_FRAC_BITS;
    localparam logic [PRW-1:0] HALF_P = PRW'(1) << (PARAM_FRAC_BITS - 1);

    logic [bcpe_pkg::CTRL_W-1:0] ctrl_reg [bcpe_pkg::NUM_CTRL];

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    logic [CW-1:0]  t_wide;
    logic [CW-1:0]  t_clamp;
    logic [TW-1:0]  tbase_reg [DEGREE];
    logic [TW-1:0]  ubase_reg [DEGREE];
    logic [TW-1:0]  tpow_reg  [DEGREE+1][DEGREE+1];
    logic [TW-1:0]  upow_reg  [DEGREE+1][DEGREE+1];
    logic [PRW-1:0] prod_reg  [DEGREE+1];
    logic [WW-1:0]  wgt_reg   [DEGREE+1];

    logic signed [bcpe_pkg::COORD_W-1:0] coord_x [DEGREE+1];
    logic signed [bcpe_pkg::COORD_W-1:0] coord_y [DEGREE+1];
    logic signed [bcpe_pkg::COORD_W-1:0] coord_z [DEGREE+1];

    bcpe_pkg::adv_t adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bcpe_pkg::NUM_CTRL; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            ctrl_reg[cfg_index] <= cfg_data;
        end
    end

    // A stage may take new data when it is empty or its content moves on.
    always_comb
    begin
        en[LAST] = !vld_reg[LAST] || !point_stall;
        for (int s = LAST - 1; s >= 0; s--)
        begin
            en[s] = !vld_reg[s] || en[s+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? param_valid : vld_reg[0];
        for (int s = 1; s < NSTG; s++)
        begin
            vld_next[s] = en[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign param_stall = !en[0];
    assign point_valid = vld_reg[LAST];

    assign t_wide  = CW'(curve_param);
    assign t_clamp = (t_wide > CW'(ONE_T)) ? CW'(ONE_T) : t_wide;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tbase_reg[0] <= t_clamp[TW-1:0];
            ubase_reg[0] <= ONE_T - t_clamp[TW-1:0];
            for (int k = 0; k <= DEGREE; k++)
            begin
                tpow_reg[0][k] <= ONE_T;
                upow_reg[0][k] <= ONE_T;
            end
        end
    end

    for (genvar s = 1; s <= DEGREE; s++)
    begin : g_pow
        logic [PRW-1:0] tmul;
        logic [PRW-1:0] umul;

        assign tmul = PRW'(tpow_reg[s-1][s-1]) * PRW'(tbase_reg[s-1]) + HALF_P;
        assign umul = PRW'(upow_reg[s-1][s-1]) * PRW'(ubase_reg[s-1]) + HALF_P;

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                for (int k = 0; k <= DEGREE; k++)
                begin
                    if (k == s)
                    begin
                        tpow_reg[s][k] <= tmul[PARAM_FRAC_BITS +: TW];
                        upow_reg[s][k] <= umul[PARAM_FRAC_BITS +: TW];
                    end
                    else
                    begin
                        tpow_reg[s][k] <= tpow_reg[s-1][k];
                        upow_reg[s][k] <= upow_reg[s-1][k];
                    end
                end
            end
        end

        if (s < DEGREE)
        begin : g_base
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    tbase_reg[s] <= tbase_reg[s-1];
                    ubase_reg[s] <= ubase_reg[s-1];
                end
            end
        end
    end

    for (genvar i = 0; i <= DEGREE; i++)
    begin : g_wgt
        logic [CPW-1:0] wsum;

        assign wsum = CPW'(bcpe_pkg::BINOM[DEGREE][i]) * CPW'(prod_reg[i]) + CPW'(HALF_P);

        always_ff @(posedge clk)
        begin
            if (en[PS])
            begin
                prod_reg[i] <= PRW'(tpow_reg[DEGREE][i]) * PRW'(upow_reg[DEGREE][DEGREE-i]);
            end
            if (en[WS])
            begin
                wgt_reg[i] <= wsum[PARAM_FRAC_BITS +: WW];
            end
        end

        if (i < bcpe_pkg::NUM_CTRL)
        begin : g_ctrl
            assign coord_x[i] = ctrl_reg[i][0  +: bcpe_pkg::COORD_W];
            assign coord_y[i] = ctrl_reg[i][16 +: bcpe_pkg::COORD_W];
            assign coord_z[i] = ctrl_reg[i][32 +: bcpe_pkg::COORD_W];
        end
        else
        begin : g_zero
            assign coord_x[i] = '0;
            assign coord_y[i] = '0;
            assign coord_z[i] = '0;
        end
    end

    assign adv.mul = en[WS+1];
    assign adv.sum = en[WS+2];
    assign adv.rnd = en[WS+3];

    bcpe_axis #(
        .DEGREE          (DEGREE),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_axis_x (
        .clk    (clk),
        .adv    (adv),
        .weight (wgt_reg),
        .coord  (coord_x),
        .point  (point_x)
    );

    bcpe_axis #(
        .DEGREE          (DEGREE),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_axis_y (
        .clk    (clk),
        .adv    (adv),
        .weight (wgt_reg),
        .coord  (coord_y),
        .point  (point_y)
    );

    bcpe_axis #(
        .DEGREE          (DEGREE),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_axis_z (
        .clk    (clk),
        .adv    (adv),
        .weight (wgt_reg),
        .coord  (coord_z),
        .point  (point_z)
    );

endmodule

[hw/rtl/bcpe_axis.sv]
// One coordinate axis: weighted products, sum, rounding and saturation.
module bcpe_axis #(
    parameter int DEGREE          = 3,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                                    clk,
    input  bcpe_pkg::adv_t                          adv,
    input  logic [PARAM_FRAC_BITS+5:0]              weight [DEGREE+1],
    input  logic signed [bcpe_pkg::COORD_W-1:0]     coord  [DEGREE+1],
    output logic signed [bcpe_pkg::COORD_W-1:0]     point
);

    localparam int WW = PARAM_FRAC_BITS + 6;
    localparam int PW = WW + 1 + bcpe_pkg::COORD_W;
    localparam int AW = PW + $clog2(DEGREE + 1) + 1;
    localparam int RW = AW - PARAM_FRAC_BITS;

    localparam logic signed [AW-1:0] HALF    = AW'(1) << (PARAM_FRAC_BITS - 1);
    localparam logic signed [RW-1:0] SAT_MAX = RW'(32767);
    localparam logic signed [RW-1:0] SAT_MIN = -RW'(32768);

    logic signed [PW-1:0]               prod_reg [DEGREE+1];
    logic signed [AW-1:0]               acc_reg;
    logic signed [AW-1:0]               acc_next;
    logic signed [AW-1:0]               acc_shift;
    logic signed [RW-1:0]               acc_round;
    logic signed [bcpe_pkg::COORD_W-1:0] point_reg;
    logic signed [bcpe_pkg::COORD_W-1:0] point_next;

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            for (int i = 0; i <= DEGREE; i++)
            begin
                prod_reg[i] <= PW'($signed({1'b0, weight[i]})) * PW'(coord[i]);
            end
        end
    end

    always_comb
    begin
        acc_next = HALF;
        for (int i = 0; i <= DEGREE; i++)
        begin
            acc_next = acc_next + AW'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.sum)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        acc_shift = acc_reg >>> PARAM_FRAC_BITS;
        acc_round = acc_shift[RW-1:0];
        if (acc_round > SAT_MAX)
        begin
            point_next = 16'sh7fff;
        end
        else if (acc_round < SAT_MIN)
        begin
            point_next = 16'sh8000;
        end
        else
        begin
            point_next = acc_round[bcpe_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.rnd)
        begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

[hw/rtl/bcpe_checker.sv]
// Port-level checks for the Bezier curve point evaluator, bound to the top level.
module bcpe_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic                                 param_stall,
    input logic                                 point_valid,
    input logic                                 point_stall,
    input logic signed [bcpe_pkg::COORD_W-1:0]  point_x,
    input logic signed [bcpe_pkg::COORD_W-1:0]  point_y,
    input logic signed [bcpe_pkg::COORD_W-1:0]  point_z
);

    // A held output beat keeps its value until it is taken.
    a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid && $stable(point_x)
            && $stable(point_y) && $stable(point_z))
        else $error("point beat changed while stalled");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // The input may only stall when a finished point is held back.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        param_stall |-> point_valid && point_stall)
        else $error("input stalled with the output free");

endmodule

bind bezier_curve_point_eval bcpe_checker u_bcpe_checker (.*);
